// ----- hdl/multiplexed_timer_queue_core_macros.svh -----
// Assertion macros used by the timer queue datapath.
`ifndef MULTIPLEXED_TIMER_QUEUE_CORE_MACROS_SVH
`define MULTIPLEXED_TIMER_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MTQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MTQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/mtq_pkg.sv -----
// Package: sizes, codes and control/status types of the timer queue.
`timescale 1ns / 1ps
`default_nettype none
package mtq_pkg;

	localparam int TIMER_SLOTS = 16;
	localparam int DELAY_BITS  = 16;
	localparam int SLOT_W      = $clog2(TIMER_SLOTS);
	localparam int LIVE_W      = $clog2(TIMER_SLOTS + 1);
	localparam int DELAY_IN_W  = 16;
	localparam int HANDLER_W   = 8;
	localparam int KIND_W      = 3;
	localparam int LIVE_OUT_W  = 5;

	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_EXPIRED   = 3'd0,
		KIND_INSERTED  = 3'd1,
		KIND_REJECTED  = 3'd2,
		KIND_DUPLICATE = 3'd3,
		KIND_FULL      = 3'd4
	} kind_t;

	typedef logic [DELAY_BITS-1:0] delay_t;
	typedef logic [HANDLER_W-1:0]  handler_t;
	typedef logic [SLOT_W-1:0]     slot_t;
	typedef logic [LIVE_W-1:0]     live_t;

	// controller -> datapath
	typedef struct packed {
		logic load_item;
		logic clr_scan;
		logic ins_step;
		logic ins_commit;
		logic tick_dec;
		logic exp_step;
		logic exp_commit;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic item_is_insert;
		logic scan_last;
		logic exp_found;
		logic res_last;
	} dp_status_t;

endpackage
`default_nettype wire

// ----- hdl/mtq_in_if.sv -----
// Input channel interface: one timer command per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface mtq_in_if;
	logic                             valid;
	logic                             ready;
	logic                             cmd;
	logic [mtq_pkg::DELAY_IN_W-1:0]  delay_ticks;
	logic [mtq_pkg::HANDLER_W-1:0]   handler_id;

	modport source (output valid, cmd, delay_ticks, handler_id, input ready);
	modport sink (input valid, cmd, delay_ticks, handler_id, output ready);
endinterface
`default_nettype wire

// ----- hdl/mtq_out_if.sv -----
// Result channel interface: one status or expiry report per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface mtq_out_if;
	logic                             valid;
	logic                             ready;
	logic [mtq_pkg::KIND_W-1:0]      kind;
	logic [mtq_pkg::HANDLER_W-1:0]   expired_handler;
	logic [mtq_pkg::LIVE_OUT_W-1:0]  live_count;
	logic                             last;

	modport source (output valid, kind, expired_handler, live_count, last, input ready);
	modport sink (input valid, kind, expired_handler, live_count, last, output ready);
endinterface
`default_nettype wire

// ----- hdl/mtq_datapath.sv -----
// Datapath: timer table, slot scan, insert/expiry logic and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "multiplexed_timer_queue_core_macros.svh"
module mtq_datapath (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire mtq_pkg::ctl_cmd_t                cmd,
	output mtq_pkg::dp_status_t                   status,
	input  wire logic                             item_cmd,
	input  wire logic [mtq_pkg::DELAY_IN_W-1:0]  item_delay,
	input  wire logic [mtq_pkg::HANDLER_W-1:0]   item_handler,
	output logic [mtq_pkg::KIND_W-1:0]           res_kind,
	output logic [mtq_pkg::HANDLER_W-1:0]        res_handler,
	output logic [mtq_pkg::LIVE_OUT_W-1:0]       res_live,
	output logic                                 res_last
);

	localparam logic [31:0] DELAY_MAX32 = 32'((64'd1 << mtq_pkg::DELAY_BITS) - 64'd1);

	function automatic mtq_pkg::delay_t sat_delay(input logic [mtq_pkg::DELAY_IN_W-1:0] d);
		logic [31:0] w;
		w = 32'(d);
		if (w > DELAY_MAX32) begin
			w = DELAY_MAX32;
		end
		return w[mtq_pkg::DELAY_BITS-1:0];
	endfunction

	logic [mtq_pkg::TIMER_SLOTS-1:0] valid_q;
	logic [mtq_pkg::TIMER_SLOTS-1:0] due_q;
	mtq_pkg::delay_t                 rem_q [mtq_pkg::TIMER_SLOTS];
	mtq_pkg::handler_t               hnd_q [mtq_pkg::TIMER_SLOTS];
	mtq_pkg::live_t                  live_q;
	mtq_pkg::slot_t                  idx_q;
	logic                            dup_q;
	logic                            free_found_q;
	mtq_pkg::slot_t                  free_slot_q;
	logic                            best_found_q;
	mtq_pkg::slot_t                  best_slot_q;
	mtq_pkg::handler_t               best_h_q;
	mtq_pkg::delay_t                 delay_q;
	mtq_pkg::handler_t               hid_q;
	mtq_pkg::kind_t                  res_kind_q;
	mtq_pkg::handler_t               res_hid_q;
	mtq_pkg::live_t                  res_live_q;
	logic                            res_last_q;

	logic                            cur_valid;
	logic                            cur_match;
	logic                            cur_better;
	logic                            ins_reject;
	logic                            ins_ok;
	logic [mtq_pkg::TIMER_SLOTS-1:0] rest_due;

	always_comb begin
		cur_valid  = valid_q[idx_q];
		cur_match  = cur_valid && (rem_q[idx_q] == delay_q) && (hnd_q[idx_q] == hid_q);
		cur_better = due_q[idx_q] && (!best_found_q || (hnd_q[idx_q] < best_h_q));
		ins_reject = (delay_q == '0) || (hid_q == '0);
		ins_ok     = !ins_reject && !dup_q && free_found_q;
		for (int i = 0; i < mtq_pkg::TIMER_SLOTS; i++) begin
			rest_due[i] = due_q[i] && (mtq_pkg::slot_t'(i) != best_slot_q);
		end
	end

	always_comb begin
		status.item_is_insert = (item_cmd == mtq_pkg::CMD_INSERT);
		status.scan_last      = (idx_q == mtq_pkg::slot_t'(mtq_pkg::TIMER_SLOTS - 1));
		status.exp_found      = best_found_q || due_q[idx_q];
		status.res_last       = res_last_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			due_q        <= '0;
			live_q       <= '0;
			idx_q        <= '0;
			dup_q        <= 1'b0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			if (cmd.load_item || cmd.clr_scan) begin
				idx_q        <= '0;
				dup_q        <= 1'b0;
				free_found_q <= 1'b0;
				best_found_q <= 1'b0;
			end else if (cmd.ins_step) begin
				idx_q <= idx_q + mtq_pkg::slot_t'(1);
				if (cur_match) begin
					dup_q <= 1'b1;
				end
				if (!cur_valid) begin
					free_found_q <= 1'b1;
				end
			end else if (cmd.exp_step) begin
				idx_q <= idx_q + mtq_pkg::slot_t'(1);
				if (cur_better) begin
					best_found_q <= 1'b1;
				end
			end
			if (cmd.tick_dec) begin
				for (int i = 0; i < mtq_pkg::TIMER_SLOTS; i++) begin
					if (valid_q[i] && (rem_q[i] == mtq_pkg::delay_t'(1))) begin
						due_q[i] <= 1'b1;
					end
				end
			end
			if (cmd.ins_commit && ins_ok) begin
				valid_q[free_slot_q] <= 1'b1;
				live_q               <= live_q + mtq_pkg::live_t'(1);
			end
			if (cmd.exp_commit) begin
				valid_q[best_slot_q] <= 1'b0;
				due_q[best_slot_q]   <= 1'b0;
				live_q               <= live_q - mtq_pkg::live_t'(1);
			end
		end
	end

	// table contents and payload
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			delay_q <= sat_delay(item_delay);
			hid_q   <= item_handler;
		end
		if (cmd.ins_step && !cur_valid && !free_found_q) begin
			free_slot_q <= idx_q;
		end
		if (cmd.exp_step && cur_better) begin
			best_slot_q <= idx_q;
			best_h_q    <= hnd_q[idx_q];
		end
		if (cmd.tick_dec) begin
			for (int i = 0; i < mtq_pkg::TIMER_SLOTS; i++) begin
				if (valid_q[i]) begin
					rem_q[i] <= rem_q[i] - mtq_pkg::delay_t'(1);
				end
			end
		end
		if (cmd.ins_commit) begin
			res_hid_q  <= hid_q;
			res_last_q <= 1'b1;
			res_live_q <= live_q;
			if (ins_reject) begin
				res_kind_q <= mtq_pkg::KIND_REJECTED;
			end else if (dup_q) begin
				res_kind_q <= mtq_pkg::KIND_DUPLICATE;
			end else if (!free_found_q) begin
				res_kind_q <= mtq_pkg::KIND_FULL;
			end else begin
				res_kind_q         <= mtq_pkg::KIND_INSERTED;
				res_live_q         <= live_q + mtq_pkg::live_t'(1);
				rem_q[free_slot_q] <= delay_q;
				hnd_q[free_slot_q] <= hid_q;
			end
		end
		if (cmd.exp_commit) begin
			res_kind_q <= mtq_pkg::KIND_EXPIRED;
			res_hid_q  <= best_h_q;
			res_live_q <= live_q - mtq_pkg::live_t'(1);
			res_last_q <= !(|rest_due);
		end
	end

	assign res_kind    = res_kind_q;
	assign res_handler = res_hid_q;
	assign res_live    = mtq_pkg::LIVE_OUT_W'(res_live_q);
	assign res_last    = res_last_q;

	`MTQ_ASSERT_IMP(a_live_matches_valid, 1'b1, (live_q == mtq_pkg::live_t'($countones(valid_q))), "live count out of step with valid bits")
	`MTQ_ASSERT_IMP(a_due_only_live, 1'b1, ((due_q & ~valid_q) == '0), "expiry pending on an empty slot")
	`MTQ_ASSERT_NXT(a_insert_grows, (cmd.ins_commit && ins_ok), (live_q != $past(live_q)), "accepted insert did not change live count")
	`MTQ_ASSERT_IMP(a_exp_has_best, cmd.exp_commit, (best_found_q && due_q[best_slot_q]), "expiry commit without a due slot")

endmodule
`default_nettype wire

// ----- hdl/mtq_ctrl.sv -----
// Controller: sequences slot scans, commits and result handshakes.
`timescale 1ns / 1ps
`default_nettype none
module mtq_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output mtq_pkg::ctl_cmd_t        cmd,
	input  wire mtq_pkg::dp_status_t status
);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_INS_SCAN = 7'b0000010,
		ST_INS_RES  = 7'b0000100,
		ST_TICK     = 7'b0001000,
		ST_EXP_SCAN = 7'b0010000,
		ST_EXP_RES  = 7'b0100000,
		ST_OUT      = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		item_ready   = 1'b0;
		result_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d = status.item_is_insert ? ST_INS_SCAN : ST_TICK;
				end
			end
			ST_INS_SCAN: begin
				cmd.ins_step = 1'b1;
				if (status.scan_last) begin
					state_d = ST_INS_RES;
				end
			end
			ST_INS_RES: begin
				cmd.ins_commit = 1'b1;
				state_d = ST_OUT;
			end
			ST_TICK: begin
				cmd.tick_dec = 1'b1;
				cmd.clr_scan = 1'b1;
				state_d = ST_EXP_SCAN;
			end
			ST_EXP_SCAN: begin
				cmd.exp_step = 1'b1;
				if (status.scan_last) begin
					state_d = status.exp_found ? ST_EXP_RES : ST_IDLE;
				end
			end
			ST_EXP_RES: begin
				cmd.exp_commit = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				result_valid = 1'b1;
				if (result_ready) begin
					if (status.res_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.clr_scan = 1'b1;
						state_d = ST_EXP_SCAN;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/multiplexed_timer_queue_core.sv -----
// Timer queue top level: controller and datapath joined to the channel interfaces.
// Insert: result valid after a scan of every slot for a duplicate and a free slot, plus the commit.
// Tick: delays decrement, then each expiry comes from a slot scan and a commit, repeated until the last is taken.
// A tick with no expiry gives no result and is back in idle after its slot scan.
// One item at a time; the next item is taken no earlier than the cycle after its last result.
// arst_n clears all valid bits, pending expiries and the live count.
`timescale 1ns / 1ps
`default_nettype none
module multiplexed_timer_queue_core (
	input  wire logic clk,
	input  wire logic arst_n,
	mtq_in_if.sink    item,
	mtq_out_if.source result
);

	mtq_pkg::ctl_cmd_t   cmd;
	mtq_pkg::dp_status_t status;

	mtq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.cmd          (cmd),
		.status       (status)
	);

	mtq_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.item_cmd     (item.cmd),
		.item_delay   (item.delay_ticks),
		.item_handler (item.handler_id),
		.res_kind     (result.kind),
		.res_handler  (result.expired_handler),
		.res_live     (result.live_count),
		.res_last     (result.last)
	);

endmodule
`default_nettype wire
